@@ design/wtsb_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the warp tile source bounds block.
package wtsb_pkg;
    localparam int POS_FRAC         = 16;
    localparam int IMAGE_DIM_MAX    = 4096;
    localparam int BUFFER_WORDS_DEF = 16384;
    localparam int NUM_W            = 49;
    localparam int DEN_W            = 48;
    localparam int QUOT_W           = 42;
    localparam int QBITS            = 41;

    typedef enum logic [2:0] {
        REG_ROW0    = 3'd0,
        REG_ROW1    = 3'd1,
        REG_ROW2    = 3'd2,
        REG_OFFS_XY = 3'd3,
        REG_OFFS_W  = 3'd4,
        REG_SRC_ROWS = 3'd5,
        REG_SRC_COLS = 3'd6,
        REG_QSHIFTS = 3'd7
    } t_cfg_idx;
endpackage

@@ design/wtsb_div.sv @@
`timescale 1ns / 1ps
// Iterative signed Q.16 divider, one quotient bit per cycle, floor rounding, saturated.
module wtsb_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [wtsb_pkg::NUM_W-1:0]       i_num,
    input  logic        [wtsb_pkg::DEN_W-1:0]       i_den,
    output logic                                    o_done,
    output logic signed [wtsb_pkg::QUOT_W-1:0]      o_quot
);
    localparam int NW = wtsb_pkg::NUM_W;
    localparam int DW = wtsb_pkg::DEN_W;
    localparam int QW = wtsb_pkg::QUOT_W;
    localparam int QB = wtsb_pkg::QBITS;
    localparam int PF = wtsb_pkg::POS_FRAC;
    localparam int HI = NW - (QB - PF);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_PREP = 4'b0010,
        D_ITER = 4'b0100,
        D_FIX  = 4'b1000
    } t_dstate;

    t_dstate                r_state;
    logic signed [NW-1:0]   r_num;
    logic        [DW-1:0]   r_den;
    logic                   r_neg;
    logic                   r_sat;
    logic        [NW-1:0]   r_rem;
    logic        [QB-1:0]   r_q;
    logic        [5:0]      r_cnt;
    logic                   r_done;
    logic signed [QW-1:0]   r_quot;

    logic        [NW-1:0]   n_mag;
    logic        [NW-1:0]   n_trial;
    logic                   n_bit;
    logic        [QW-1:0]   n_qadj;
    logic        [QW-1:0]   n_qsat;

    always_comb begin
        n_mag   = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
        n_trial = {r_rem[NW-2:0], r_q[QB-1]};
        n_bit   = n_trial >= {1'b0, r_den};
        n_qadj  = QW'(r_q) + QW'(r_neg && (r_rem != '0));
        if (r_sat || n_qadj > (QW'(1) << (QB - 1))) begin
            n_qsat = QW'(1) << (QB - 1);
        end else begin
            n_qsat = n_qadj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == D_FIX);
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_state <= D_PREP;
                    end
                end
                D_PREP: begin
                    r_neg <= r_num[NW-1];
                    r_sat <= {{(DW-(NW-HI)){1'b0}}, n_mag[NW-1:HI]} >= r_den;
                    r_cnt <= 6'(QB - 1);
                    if ({{(DW-(NW-HI)){1'b0}}, n_mag[NW-1:HI]} >= r_den) begin
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_state <= D_FIX;
                    end else begin
                        r_rem   <= NW'(n_mag[NW-1:HI]);
                        r_q     <= {n_mag[HI-1:0], {(PF+1){1'b0}}};
                        r_state <= D_ITER;
                    end
                end
                D_ITER: begin
                    r_rem <= n_bit ? (n_trial - {1'b0, r_den}) : n_trial;
                    r_q   <= {r_q[QB-2:0], n_bit};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    r_quot  <= r_neg ? -$signed(n_qsat) : $signed(n_qsat);
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

@@ design/warp_tile_source_bounds_core.sv @@
`timescale 1ns / 1ps
// Top level: projects tile corners through a homography and forms the source bounding box.
// From input accept to output valid: four corners of six
// multiply-accumulate steps and two divisions on the shared divider,
// then box, area and output stages. No new tile is taken until the last
// is loaded into the output word; a stalled output word holds the last stage.
// A tile whose corner has w <= 0 skips that corner's divisions and finishes sooner.
// Reset (synchronous, active low) loads register defaults and sets the running area to 1.
module warp_tile_source_bounds_core #(
    parameter int BUFFER_WORDS = wtsb_pkg::BUFFER_WORDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tile_row_start[11:0], tile_col_start[23:12], tile_rows[36:24], tile_cols[49:37]
    input  logic [55:0]  s_axis_tdata,
    // start_of_plan[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // src_row_start[11:0], src_col_start[23:12], src_rows[36:24], src_cols[49:37],
    // src_area[74:50], largest_area[99:75]
    output logic [103:0] m_axis_tdata,
    // too_big[0], bad_divisor[1]
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    localparam int NW = wtsb_pkg::NUM_W;
    localparam int DW = wtsb_pkg::DEN_W;
    localparam int QW = wtsb_pkg::QUOT_W;
    localparam int PF = wtsb_pkg::POS_FRAC;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_DIV  = 6'b000100,
        S_BOX  = 6'b001000,
        S_AREA = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    typedef struct packed {
        logic [11:0] start;
        logic [12:0] span;
    } t_axis;

    function automatic logic [12:0] eff_dim(input logic [12:0] v);
        if (v == 13'd0) return 13'd1;
        if (v > 13'(wtsb_pkg::IMAGE_DIM_MAX)) return 13'(wtsb_pkg::IMAGE_DIM_MAX);
        return v;
    endfunction

    function automatic t_axis axis_box(input logic signed [QW-1:0] lo,
                                       input logic signed [QW-1:0] hi,
                                       input logic [12:0] dim,
                                       input logic [3:0] qsh);
        logic signed [QW:0] lom;
        logic signed [QW:0] top;
        logic [27:0] m;
        logic [27:0] mx;
        logic [15:0] qmask;
        logic [15:0] s;
        logic [15:0] e;
        t_axis r;
        top   = (QW+1)'(dim - 13'd1) <<< PF;
        lom   = (QW+1)'(lo) - ((QW+1)'(1) <<< PF);
        qmask = (16'd1 << qsh) - 16'd1;
        if (lom < 0) m = '0;
        else if (lom > top) m = 28'(top);
        else m = 28'(lom);
        if (hi < 0) mx = '0;
        else if ((QW+1)'(hi) > top) mx = 28'(top);
        else mx = 28'(hi);
        s = 16'((m + 28'hFFFF) >> PF);
        e = 16'(mx >> PF) + 16'd1;
        s = s & ~qmask;
        e = e | qmask;
        if (e > 16'(dim - 13'd1)) e = 16'(dim - 13'd1);
        r.start = s[11:0];
        r.span  = 13'(e - s + 16'd1);
        return r;
    endfunction

    t_state               r_state;
    logic [63:0]          r_row0, r_row1, r_row2, r_offs;
    logic [31:0]          r_offw;
    logic [12:0]          r_srows, r_scols;
    logic [7:0]           r_qsh;
    logic [24:0]          r_max;
    logic                 r_sop;
    logic [11:0]          r_r0, r_k0;
    logic [12:0]          r_tr, r_tc;
    logic [1:0]           r_corner;
    logic [2:0]           r_step;
    logic signed [NW-1:0] r_acc;
    logic [DW-1:0]        r_w;
    logic                 r_bad;
    logic signed [QW-1:0] r_xlo, r_xhi, r_ylo, r_yhi;
    t_axis                r_rbox, r_cbox;
    logic [24:0]          r_area;
    logic                 r_oval;
    logic [103:0]         r_odata;
    logic [1:0]           r_ouser;
    logic                 r_div_start;

    logic [13:0]          n_u, n_v, n_a;
    logic signed [31:0]   n_b, n_off;
    logic signed [46:0]   n_prod;
    logic signed [NW-1:0] n_base, n_acc;
    logic                 div_done;
    logic signed [QW-1:0] div_quot;
    logic [24:0]          n_cur, n_max;
    logic                 n_load;

    always_comb begin
        n_u = 14'(r_k0) + (r_corner[1] ? 14'(r_tc) : 14'd0);
        n_v = 14'(r_r0) + (r_corner[0] ? 14'(r_tr) : 14'd0);
        n_a = r_step[0] ? n_v : n_u;
        case (r_step)
            3'd0: begin n_b = r_row2[63:32]; n_off = r_offw;          end
            3'd1: begin n_b = r_row2[31:0];  n_off = r_offw;          end
            3'd2: begin n_b = r_row0[63:32]; n_off = r_offs[63:32];   end
            3'd3: begin n_b = r_row0[31:0];  n_off = r_offs[63:32];   end
            3'd4: begin n_b = r_row1[63:32]; n_off = r_offs[31:0];    end
            3'd5: begin n_b = r_row1[31:0];  n_off = r_offs[31:0];    end
            default: begin n_b = '0; n_off = '0; end
        endcase
        n_prod = $signed({1'b0, n_a}) * n_b;
        n_base = r_step[0] ? r_acc : NW'(n_off);
        n_acc  = n_base + NW'(n_prod);
        n_cur  = r_sop ? 25'd1 : r_max;
        n_max  = (r_area > n_cur) ? r_area : n_cur;
        n_load = (r_state == S_DONE) && (!r_oval || m_axis_tready);
    end

    wtsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_acc),
        .i_den   (r_w),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0  <= 64'd281474976710656;
            r_row1  <= 64'd65536;
            r_row2  <= '0;
            r_offs  <= '0;
            r_offw  <= 32'd65536;
            r_srows <= 13'd4096;
            r_scols <= 13'd4096;
            r_qsh   <= 8'd112;
        end else if (i_cfg_valid) begin
            case (wtsb_pkg::t_cfg_idx'(i_cfg_index))
                wtsb_pkg::REG_ROW0:     r_row0  <= i_cfg_data;
                wtsb_pkg::REG_ROW1:     r_row1  <= i_cfg_data;
                wtsb_pkg::REG_ROW2:     r_row2  <= i_cfg_data;
                wtsb_pkg::REG_OFFS_XY:  r_offs  <= i_cfg_data;
                wtsb_pkg::REG_OFFS_W:   r_offw  <= i_cfg_data[31:0];
                wtsb_pkg::REG_SRC_ROWS: r_srows <= i_cfg_data[12:0];
                wtsb_pkg::REG_SRC_COLS: r_scols <= i_cfg_data[12:0];
                wtsb_pkg::REG_QSHIFTS:  r_qsh   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= 25'd1;
            r_oval      <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_MAC) && (r_step == 3'd3 || r_step == 3'd5);
            if (r_oval && m_axis_tready && !n_load) r_oval <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_sop    <= s_axis_tuser;
                        r_r0     <= s_axis_tdata[11:0];
                        r_k0     <= s_axis_tdata[23:12];
                        r_tr     <= s_axis_tdata[36:24];
                        r_tc     <= s_axis_tdata[49:37];
                        r_corner <= 2'd0;
                        r_step   <= 3'd0;
                        r_bad    <= 1'b0;
                        r_xlo    <= '0;
                        r_xhi    <= '0;
                        r_ylo    <= '0;
                        r_yhi    <= '0;
                        r_state  <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_acc <= n_acc;
                    if (r_step == 3'd1) begin
                        if (n_acc <= 0) begin
                            r_bad  <= 1'b1;
                            r_step <= 3'd0;
                            if (r_corner == 2'd3) r_state <= S_BOX;
                            r_corner <= r_corner + 2'd1;
                        end else begin
                            r_w    <= DW'(n_acc);
                            r_step <= 3'd2;
                        end
                    end else if (r_step == 3'd3 || r_step == 3'd5) begin
                        r_step      <= r_step + 3'd1;
                        r_state     <= S_DIV;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_step == 3'd4) begin
                            if (r_corner == 2'd0 || div_quot < r_xlo) r_xlo <= div_quot;
                            if (r_corner == 2'd0 || div_quot > r_xhi) r_xhi <= div_quot;
                            r_state <= S_MAC;
                        end else begin
                            if (r_corner == 2'd0 || div_quot < r_ylo) r_ylo <= div_quot;
                            if (r_corner == 2'd0 || div_quot > r_yhi) r_yhi <= div_quot;
                            r_step   <= 3'd0;
                            r_corner <= r_corner + 2'd1;
                            r_state  <= (r_corner == 2'd3) ? S_BOX : S_MAC;
                        end
                    end
                end
                S_BOX: begin
                    if (r_bad) begin
                        r_rbox <= '{start: 12'd0, span: eff_dim(r_srows)};
                        r_cbox <= '{start: 12'd0, span: eff_dim(r_scols)};
                    end else begin
                        r_rbox <= axis_box(r_ylo, r_yhi, eff_dim(r_srows), r_qsh[3:0]);
                        r_cbox <= axis_box(r_xlo, r_xhi, eff_dim(r_scols), r_qsh[7:4]);
                    end
                    r_state <= S_AREA;
                end
                S_AREA: begin
                    r_area  <= 25'(r_rbox.span) * 25'(r_cbox.span);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_load) begin
                        r_max   <= n_max;
                        r_odata <= {4'd0, n_max, r_area, r_cbox.span, r_rbox.span,
                                    r_cbox.start, r_rbox.start};
                        r_ouser <= {r_bad, r_area > 25'(BUFFER_WORDS)};
                        r_oval  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
endmodule

@@ design/wtsb_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the warp tile source bounds block, with its bind.
module wtsb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a word while busy");

    a_bad_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[23:0] == 24'd0)
        else $error("bad divisor box does not start at origin");

    a_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[74:50] != 25'd0 &&
                          m_axis_tdata[99:75] >= m_axis_tdata[74:50])
        else $error("area bookkeeping broken");
endmodule

bind warp_tile_source_bounds_core wtsb_checker u_wtsb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
